FILE: design/lrd_pkg.sv
package lrd_pkg;

	localparam int MAX_PAYLOAD = 256;
	localparam int PAY_WORDS = (MAX_PAYLOAD + 7) / 8;
	localparam int WADDR_W = (PAY_WORDS > 1) ? $clog2(PAY_WORDS) : 1;
	localparam int PLEN_W = 9;
	localparam int WCNT_W = PLEN_W - 2;
	localparam logic [31:0] FIXED_BODY = 32'd25;
	localparam logic [31:0] CRC_POLY = 32'hEDB88320;

	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_WORD = 2'd1;
	localparam logic [1:0] KIND_SUMMARY = 2'd2;

	localparam logic [2:0] STOP_CLEAN = 3'd0;
	localparam logic [2:0] STOP_PARTIAL = 3'd1;
	localparam logic [2:0] STOP_SHORT = 3'd2;
	localparam logic [2:0] STOP_MISMATCH = 3'd3;
	localparam logic [2:0] STOP_CRC = 3'd4;
	localparam logic [2:0] STOP_TOO_LARGE = 3'd5;

	localparam logic ACT_BYTE = 1'b0;
	localparam logic ACT_END = 1'b1;

	typedef struct packed {
		logic action;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [63:0] seq_number;
		logic [63:0] txn_ident;
		logic [7:0] record_kind;
		logic [8:0] payload_bytes;
		logic [63:0] payload_word;
		logic [3:0] word_fill;
		logic last;
		logic [63:0] largest_seq;
		logic [63:0] following_seq;
		logic [2:0] stop_cause;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HDR,
		ST_RD,
		ST_WORD
	} ctrl_state_t;

	typedef struct packed {
		logic accept;
		logic load_hdr;
		logic rd;
		logic load_word;
	} lrd_cmd_t;

	typedef struct packed {
		logic start_emit;
		logic no_words;
		logic last_word;
		logic out_free;
	} lrd_stat_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? (CRC_POLY ^ (r >> 1)) : (r >> 1);
		end
		return r;
	endfunction

endpackage

FILE: design/lrd_ctrl.sv
module lrd_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  lrd_pkg::lrd_stat_t stat,
	output lrd_pkg::lrd_cmd_t cmd
);
	import lrd_pkg::*;

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.accept && stat.start_emit) state_d = ST_HDR;
			end
			ST_HDR: begin
				if (stat.out_free) state_d = stat.no_words ? ST_IDLE : ST_RD;
			end
			ST_RD: begin
				state_d = ST_WORD;
			end
			ST_WORD: begin
				if (stat.out_free) state_d = stat.last_word ? ST_IDLE : ST_RD;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				in_stall = !stat.out_free;
				cmd.accept = in_valid && stat.out_free;
			end
			ST_HDR: begin
				cmd.load_hdr = stat.out_free;
			end
			ST_RD: begin
				cmd.rd = 1'b1;
			end
			ST_WORD: begin
				cmd.load_word = stat.out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

FILE: design/lrd_datapath.sv
module lrd_datapath (
	input  logic clk,
	input  logic arst_n,
	input  lrd_pkg::in_item_t in_item,
	input  logic cfg_valid,
	input  logic cfg_data,
	input  logic out_stall,
	output logic out_valid,
	output lrd_pkg::out_item_t out_item,
	input  lrd_pkg::lrd_cmd_t cmd,
	output lrd_pkg::lrd_stat_t stat
);
	import lrd_pkg::*;

	logic deliver_q;
	logic body_q;
	logic [31:0] cnt_q;
	logic [31:0] rec_len_q;
	logic [63:0] seq_q;
	logic [63:0] txn_q;
	logic [7:0] kind_q;
	logic [31:0] plen_field_q;
	logic [31:0] crc_q;
	logic [31:0] crc_rx_q;
	logic [63:0] seq_max_q;
	logic halted_q;
	logic [2:0] reason_q;
	logic [PLEN_W-1:0] plen_q;
	logic [WADDR_W-1:0] w_q;
	logic [63:0] rdata_q;
	logic out_valid_q;
	out_item_t out_q;
	logic [63:0] mem [PAY_WORDS];

	logic [7:0] b;
	logic byte_go;
	logic [31:0] cnt_inc;
	logic [31:0] crc_start;
	logic [31:0] pidx;
	logic [31:0] plen32;
	logic [31:0] rx_full;
	logic [31:0] len_full;
	logic finish;
	logic good;
	logic [2:0] fail_cause;
	logic [WCNT_W-1:0] words;
	logic [WCNT_W-1:0] w_ext;
	logic [PLEN_W-1:0] fill_raw;
	logic [3:0] fill;
	logic [63:0] masked;
	logic load_sum;
	logic load_out;
	out_item_t out_d;

	assign b = in_item.data_byte;
	assign byte_go = cmd.accept && (in_item.action == ACT_BYTE) && !halted_q;
	assign cnt_inc = cnt_q + 32'd1;
	assign crc_start = rec_len_q - 32'd4;
	assign pidx = cnt_q - 32'd21;
	assign plen32 = rec_len_q - FIXED_BODY;
	assign rx_full = {b, crc_rx_q[23:0]};
	assign len_full = {b, rec_len_q[23:0]};
	assign finish = byte_go && body_q && (cnt_inc == rec_len_q);
	assign load_sum = cmd.accept && (in_item.action == ACT_END);
	assign load_out = cmd.load_hdr || cmd.load_word || load_sum;

	always_comb begin
		fail_cause = STOP_CLEAN;
		if (plen_field_q != plen32) fail_cause = STOP_MISMATCH;
		else if ((crc_q ^ 32'hFFFFFFFF) != rx_full) fail_cause = STOP_CRC;
		else if (plen32 > 32'(MAX_PAYLOAD)) fail_cause = STOP_TOO_LARGE;
	end
	assign good = (fail_cause == STOP_CLEAN);

	assign words = WCNT_W'((10'(plen_q) + 10'd7) >> 3);
	assign w_ext = WCNT_W'(w_q);
	assign fill_raw = plen_q - PLEN_W'({w_q, 3'b000});
	assign fill = (fill_raw > PLEN_W'(8)) ? 4'd8 : fill_raw[3:0];

	always_comb begin
		for (int j = 0; j < 8; j++) begin
			masked[j*8 +: 8] = (4'(j) < fill) ? rdata_q[j*8 +: 8] : 8'd0;
		end
	end

	always_comb begin
		stat.start_emit = finish && good && deliver_q;
		stat.no_words = (words == '0);
		stat.last_word = (w_ext + WCNT_W'(1) == words);
		stat.out_free = !out_valid_q || !out_stall;
	end

	always_comb begin
		out_d = '0;
		if (load_sum) begin
			out_d.kind = KIND_SUMMARY;
			out_d.last = 1'b1;
			out_d.largest_seq = seq_max_q;
			out_d.following_seq = seq_max_q + 64'd1;
			if (halted_q) out_d.stop_cause = reason_q;
			else if (!body_q && cnt_q == 32'd0) out_d.stop_cause = STOP_CLEAN;
			else out_d.stop_cause = STOP_PARTIAL;
		end else if (cmd.load_hdr) begin
			out_d.kind = KIND_HEADER;
			out_d.seq_number = seq_q;
			out_d.txn_ident = txn_q;
			out_d.record_kind = kind_q;
			out_d.payload_bytes = plen_q;
			out_d.last = stat.no_words;
		end else begin
			out_d.kind = KIND_WORD;
			out_d.payload_word = masked;
			out_d.word_fill = fill;
			out_d.last = stat.last_word;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deliver_q <= 1'b1;
		end else if (cfg_valid) begin
			deliver_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_go && body_q && (cnt_q < crc_start) && (cnt_q >= 32'd21)
				&& (pidx < 32'(MAX_PAYLOAD))) begin
			mem[pidx[WADDR_W+2:3]][pidx[2:0]*8 +: 8] <= b;
		end
		if (cmd.rd) begin
			rdata_q <= mem[w_q];
		end
	end

	always_ff @(posedge clk) begin
		if (byte_go) begin
			if (!body_q) begin
				rec_len_q[cnt_q[1:0]*8 +: 8] <= b;
			end else if (cnt_q >= crc_start) begin
				crc_rx_q[2'(cnt_q[1:0] - crc_start[1:0])*8 +: 8] <= b;
			end else if (cnt_q < 32'd8) begin
				seq_q[cnt_q[2:0]*8 +: 8] <= b;
			end else if (cnt_q < 32'd16) begin
				txn_q[cnt_q[2:0]*8 +: 8] <= b;
			end else if (cnt_q == 32'd16) begin
				kind_q <= b;
			end else if (cnt_q < 32'd21) begin
				plen_field_q[2'(cnt_q[1:0] - 2'd1)*8 +: 8] <= b;
			end
		end
		if (finish) begin
			plen_q <= plen32[PLEN_W-1:0];
		end
		if (load_out) begin
			out_q <= out_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			body_q <= 1'b0;
			cnt_q <= '0;
			crc_q <= 32'hFFFFFFFF;
			seq_max_q <= '0;
			halted_q <= 1'b0;
			reason_q <= STOP_CLEAN;
			w_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept && in_item.action == ACT_END) begin
				body_q <= 1'b0;
				cnt_q <= '0;
				crc_q <= 32'hFFFFFFFF;
				seq_max_q <= '0;
				halted_q <= 1'b0;
				reason_q <= STOP_CLEAN;
			end else if (byte_go) begin
				if (!body_q) begin
					if (cnt_q[1:0] == 2'd3) begin
						cnt_q <= '0;
						if (len_full < FIXED_BODY) begin
							halted_q <= 1'b1;
							reason_q <= STOP_SHORT;
						end else begin
							body_q <= 1'b1;
						end
					end else begin
						cnt_q <= cnt_inc;
					end
				end else if (finish) begin
					body_q <= 1'b0;
					cnt_q <= '0;
					crc_q <= 32'hFFFFFFFF;
					if (good) begin
						if (seq_q > seq_max_q) seq_max_q <= seq_q;
					end else begin
						halted_q <= 1'b1;
						reason_q <= fail_cause;
					end
				end else begin
					cnt_q <= cnt_inc;
					if (cnt_q < crc_start) crc_q <= crc_byte(crc_q, b);
				end
			end
			if (stat.start_emit) begin
				w_q <= '0;
			end else if (cmd.load_word) begin
				w_q <= w_q + WADDR_W'(1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: design/log_record_deframer_crc32.sv
// Length-prefixed log record parser with CRC-32 body check.
// Input channel in_valid/in_stall/in_item: one log byte, or an end-of-log mark.
// Output channel out_valid/out_stall/out_item: header, payload word or summary.
// Configuration channel cfg_valid/cfg_ready/cfg_data sets record delivery
// (reset value 1); cfg_ready is always high.
// Log bytes stream at one per cycle while the output register is free and no
// record is being emitted. The record's last byte checks length, CRC and size
// in that cycle. A good delivered record then holds the input while its header
// is loaded and, per payload word, one payload memory read and one load.
// End of log loads a summary into the output register the next cycle and
// returns all parse state to reset.
// Reset clears parse state, the running maximum and the output valid flag;
// the payload memory is not cleared.
// When the receiver stalls, the output register holds its item and the input
// is stalled until the item is taken.
module log_record_deframer_crc32 (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  lrd_pkg::in_item_t in_item,
	output logic out_valid,
	input  logic out_stall,
	output lrd_pkg::out_item_t out_item,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic cfg_data
);
	import lrd_pkg::*;

	lrd_cmd_t cmd;
	lrd_stat_t stat;

	assign cfg_ready = 1'b1;

	lrd_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.stat(stat),
		.cmd(cmd)
	);

	lrd_datapath u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.in_item(in_item),
		.cfg_valid(cfg_valid && cfg_ready),
		.cfg_data(cfg_data),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.out_item(out_item),
		.cmd(cmd),
		.stat(stat)
	);

endmodule
